// ----- design/eeg_pkg.sv -----
// ----------------------------------------------------------------------------
// eeg_pkg
// shared types, codes and sizes of the eeg headset packet parser
// ----------------------------------------------------------------------------
package eeg_pkg;

   localparam int BAND_COUNT  = 8;
   localparam int ENTRY_COUNT = 4 + BAND_COUNT;
   localparam int ADDR_W      = $clog2(ENTRY_COUNT);
   localparam int FLAG_W      = ENTRY_COUNT;
   localparam int VALUE_W     = 24;
   localparam int BAND_IDX_W  = $clog2(BAND_COUNT + 1);

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [FLAG_W-1:0]  flags_type;
   typedef logic [VALUE_W-1:0] value_type;

   // staging store entries
   localparam addr_type ENT_QUALITY    = addr_type'(0);
   localparam addr_type ENT_ATTENTION  = addr_type'(1);
   localparam addr_type ENT_MEDITATION = addr_type'(2);
   localparam addr_type ENT_RAW        = addr_type'(3);
   localparam addr_type ENT_BAND0      = addr_type'(4);

   // received byte codes
   localparam logic [7:0] SYNC_BYTE       = 8'hAA;
   localparam logic [7:0] EXT_BYTE        = 8'h55;
   localparam logic [7:0] MAX_LEN         = 8'd170;
   localparam logic [7:0] CODE_QUALITY    = 8'h02;
   localparam logic [7:0] CODE_ATTENTION  = 8'h04;
   localparam logic [7:0] CODE_MEDITATION = 8'h05;
   localparam logic [7:0] CODE_RAW        = 8'h80;
   localparam logic [7:0] CODE_BANDS      = 8'h83;

   // result codes
   localparam logic [1:0] ST_VALUE    = 2'd0;
   localparam logic [1:0] ST_CSUM_BAD = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;

   localparam logic [2:0] KIND_QUALITY    = 3'd0;
   localparam logic [2:0] KIND_ATTENTION  = 3'd1;
   localparam logic [2:0] KIND_MEDITATION = 3'd2;
   localparam logic [2:0] KIND_RAW        = 3'd3;
   localparam logic [2:0] KIND_BAND       = 3'd4;

   typedef enum logic [2:0] {
      PH_SYNC1,
      PH_SYNC2,
      PH_LEN,
      PH_CODE,
      PH_SINGLE,
      PH_VLEN,
      PH_VALUE,
      PH_CSUM
   } phase_type;

   typedef struct packed {
      logic      en;
      addr_type  addr;
      value_type data;
   } ram_wr_type;

   typedef struct packed {
      logic      fire;
      logic      good;
      flags_type flags;
   } pkt_end_type;

endpackage

// ----- design/eeg_ram.sv -----
// ----------------------------------------------------------------------------
// eeg_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module eeg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/eeg_parser.sv -----
// ----------------------------------------------------------------------------
// eeg_parser
// byte framing and row parsing, writes staged values into the staging ram
// ----------------------------------------------------------------------------
module eeg_parser
   import eeg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_accept,
   input  logic [7:0]  req_in_byte,
   output logic        need_ram,
   output ram_wr_type  wr,
   output pkt_end_type pkt_end
);

   phase_type              phase_ff, phase_in;
   logic [7:0]             bytes_left_ff, bytes_left_in;
   logic [7:0]             sum_ff, sum_in;
   logic                   ext_ff, ext_in;
   logic [7:0]             code_ff, code_in;
   logic [7:0]             vleft_ff, vleft_in;
   logic [1:0]             idx_ff, idx_in;
   logic [1:0]             mod3_ff, mod3_in;
   logic [BAND_IDX_W-1:0]  band_ff, band_in;
   value_type              shift_ff, shift_in;
   flags_type              flags_ff, flags_in;

   logic [7:0] b;
   value_type  shift_next;

   assign b          = req_in_byte;
   assign shift_next = {shift_ff[VALUE_W-9:0], b};
   assign need_ram   = phase_ff inside {PH_CODE, PH_SINGLE, PH_VLEN, PH_VALUE, PH_CSUM};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SYNC1;
         bytes_left_ff <= '0;
         sum_ff        <= '0;
         ext_ff        <= 1'b0;
         code_ff       <= '0;
         vleft_ff      <= '0;
         idx_ff        <= '0;
         mod3_ff       <= '0;
         band_ff       <= '0;
         shift_ff      <= '0;
         flags_ff      <= '0;
      end else begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         sum_ff        <= sum_in;
         ext_ff        <= ext_in;
         code_ff       <= code_in;
         vleft_ff      <= vleft_in;
         idx_ff        <= idx_in;
         mod3_ff       <= mod3_in;
         band_ff       <= band_in;
         shift_ff      <= shift_in;
         flags_ff      <= flags_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      sum_in        = sum_ff;
      ext_in        = ext_ff;
      code_in       = code_ff;
      vleft_in      = vleft_ff;
      idx_in        = idx_ff;
      mod3_in       = mod3_ff;
      band_in       = band_ff;
      shift_in      = shift_ff;
      flags_in      = flags_ff;
      wr            = '0;
      pkt_end       = '0;
      if (req_accept) begin
         case (phase_ff)
            PH_SYNC1: begin
               if (b == SYNC_BYTE) begin
                  phase_in = PH_SYNC2;
               end
            end
            PH_SYNC2: begin
               phase_in = (b == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
            end
            PH_LEN: begin
               if (b == MAX_LEN) begin
                  phase_in = PH_LEN;
               end else if (b > MAX_LEN || b == 8'd0) begin
                  phase_in = PH_SYNC1;
               end else begin
                  bytes_left_in = b;
                  sum_in        = '0;
                  ext_in        = 1'b0;
                  code_in       = '0;
                  vleft_in      = '0;
                  idx_in        = '0;
                  mod3_in       = '0;
                  band_in       = '0;
                  shift_in      = '0;
                  flags_in      = '0;
                  phase_in      = PH_CODE;
               end
            end
            PH_CODE, PH_SINGLE, PH_VLEN, PH_VALUE: begin
               sum_in        = sum_ff + b;
               bytes_left_in = bytes_left_ff - 8'd1;
               case (phase_ff)
                  PH_CODE: begin
                     if (b == EXT_BYTE) begin
                        ext_in = 1'b1;
                     end else begin
                        code_in  = b;
                        phase_in = (!b[7] && !ext_ff) ? PH_SINGLE : PH_VLEN;
                     end
                  end
                  PH_SINGLE: begin
                     wr.data = {16'd0, b};
                     if (code_ff == CODE_QUALITY) begin
                        wr.en   = 1'b1;
                        wr.addr = ENT_QUALITY;
                     end else if (code_ff == CODE_ATTENTION) begin
                        wr.en   = 1'b1;
                        wr.addr = ENT_ATTENTION;
                     end else if (code_ff == CODE_MEDITATION) begin
                        wr.en   = 1'b1;
                        wr.addr = ENT_MEDITATION;
                     end
                     if (wr.en) begin
                        flags_in[wr.addr] = 1'b1;
                     end
                     ext_in   = 1'b0;
                     phase_in = PH_CODE;
                  end
                  PH_VLEN: begin
                     vleft_in = b;
                     idx_in   = '0;
                     mod3_in  = '0;
                     band_in  = '0;
                     shift_in = '0;
                     if (b == 8'd0) begin
                        ext_in   = 1'b0;
                        phase_in = PH_CODE;
                     end else begin
                        phase_in = PH_VALUE;
                     end
                  end
                  default: begin
                     shift_in = shift_next;
                     if (code_ff == CODE_RAW) begin
                        if (idx_ff == 2'd1) begin
                           wr.en   = 1'b1;
                           wr.addr = ENT_RAW;
                           wr.data = {8'd0, shift_next[15:0]};
                           flags_in[ENT_RAW] = 1'b1;
                        end
                     end else if (code_ff == CODE_BANDS) begin
                        if (mod3_ff == 2'd0) begin
                           shift_in = {16'd0, b};
                        end else if (mod3_ff == 2'd2 &&
                                     band_ff < BAND_IDX_W'(BAND_COUNT)) begin
                           wr.en   = 1'b1;
                           wr.addr = ENT_BAND0 + ADDR_W'(band_ff);
                           wr.data = shift_next;
                           flags_in[wr.addr] = 1'b1;
                        end
                     end
                     // group position and band counter
                     if (mod3_ff == 2'd2) begin
                        mod3_in = 2'd0;
                        if (band_ff < BAND_IDX_W'(BAND_COUNT)) begin
                           band_in = band_ff + BAND_IDX_W'(1);
                        end
                     end else begin
                        mod3_in = mod3_ff + 2'd1;
                     end
                     if (idx_ff != 2'd2) begin
                        idx_in = idx_ff + 2'd1;
                     end
                     vleft_in = vleft_ff - 8'd1;
                     if (vleft_ff == 8'd1) begin
                        ext_in   = 1'b0;
                        phase_in = PH_CODE;
                     end
                  end
               endcase
               if (bytes_left_ff == 8'd1) begin
                  phase_in = PH_CSUM;
               end
            end
            PH_CSUM: begin
               pkt_end.fire  = 1'b1;
               pkt_end.good  = (b == ~sum_ff);
               pkt_end.flags = flags_ff;
               flags_in      = '0;
               phase_in      = PH_SYNC1;
            end
            default: begin
               phase_in = PH_SYNC1;
            end
         endcase
      end
   end

endmodule

// ----- design/eeg_drain.sv -----
// ----------------------------------------------------------------------------
// eeg_drain
// reads the updated staging entries after a packet and delivers the results
// ----------------------------------------------------------------------------
module eeg_drain
   import eeg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  pkt_end_type pkt_end,
   output logic        busy,
   output logic        rd_en,
   output addr_type    rd_addr,
   input  value_type   rd_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_kind,
   output logic [2:0]  rsp_band,
   output logic [23:0] rsp_value,
   output logic        rsp_last
);

   flags_type  drain_ff, drain_in;
   logic       p_valid_ff, p_valid_in;
   logic       p_ram_ff, p_ram_in;
   logic [1:0] p_status_ff, p_status_in;
   logic [2:0] p_kind_ff, p_kind_in;
   logic [2:0] p_band_ff, p_band_in;
   logic       p_last_ff, p_last_in;

   logic       o_valid_ff, o_valid_in;
   logic [1:0] o_status_ff, o_status_in;
   logic [2:0] o_kind_ff, o_kind_in;
   logic [2:0] o_band_ff, o_band_in;
   value_type  o_value_ff, o_value_in;
   logic       o_last_ff, o_last_in;

   logic       o_free, p_move, p_free, issue;
   addr_type   pick;
   flags_type  drain_left;

   assign o_free = !o_valid_ff || !rsp_stall;
   assign p_move = p_valid_ff && o_free;
   assign p_free = !p_valid_ff || p_move;
   assign issue  = (drain_ff != '0) && p_free;
   assign busy   = (drain_ff != '0) || p_valid_ff;

   // lowest pending entry first
   always_comb begin
      pick = '0;
      for (int i = FLAG_W - 1; i >= 0; i--) begin
         if (drain_ff[i]) begin
            pick = addr_type'(i);
         end
      end
   end

   always_comb begin
      drain_left       = drain_ff;
      drain_left[pick] = 1'b0;
   end

   assign rd_en   = issue;
   assign rd_addr = pick;

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff   <= '0;
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         drain_ff   <= drain_in;
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ram_ff    <= p_ram_in;
      p_status_ff <= p_status_in;
      p_kind_ff   <= p_kind_in;
      p_band_ff   <= p_band_in;
      p_last_ff   <= p_last_in;
      o_status_ff <= o_status_in;
      o_kind_ff   <= o_kind_in;
      o_band_ff   <= o_band_in;
      o_value_ff  <= o_value_in;
      o_last_ff   <= o_last_in;
   end

   always_comb begin
      drain_in    = drain_ff;
      p_valid_in  = p_valid_ff && !p_move;
      p_ram_in    = p_ram_ff;
      p_status_in = p_status_ff;
      p_kind_in   = p_kind_ff;
      p_band_in   = p_band_ff;
      p_last_in   = p_last_ff;
      if (issue) begin
         drain_in    = drain_left;
         p_valid_in  = 1'b1;
         p_ram_in    = 1'b1;
         p_status_in = ST_VALUE;
         p_band_in   = 3'd0;
         p_last_in   = (drain_left == '0);
         if (pick == ENT_QUALITY) begin
            p_kind_in = KIND_QUALITY;
         end else if (pick == ENT_ATTENTION) begin
            p_kind_in = KIND_ATTENTION;
         end else if (pick == ENT_MEDITATION) begin
            p_kind_in = KIND_MEDITATION;
         end else if (pick == ENT_RAW) begin
            p_kind_in = KIND_RAW;
         end else begin
            p_kind_in = KIND_BAND;
            p_band_in = 3'(pick - ENT_BAND0);
         end
      end else if (pkt_end.fire) begin
         if (pkt_end.good && pkt_end.flags != '0) begin
            drain_in = pkt_end.flags;
         end else begin
            p_valid_in  = 1'b1;
            p_ram_in    = 1'b0;
            p_status_in = pkt_end.good ? ST_EMPTY : ST_CSUM_BAD;
            p_kind_in   = KIND_QUALITY;
            p_band_in   = 3'd0;
            p_last_in   = 1'b1;
         end
      end
   end

   always_comb begin
      o_valid_in  = o_valid_ff && rsp_stall;
      o_status_in = o_status_ff;
      o_kind_in   = o_kind_ff;
      o_band_in   = o_band_ff;
      o_value_in  = o_value_ff;
      o_last_in   = o_last_ff;
      if (p_move) begin
         o_valid_in  = 1'b1;
         o_status_in = p_status_ff;
         o_kind_in   = p_kind_ff;
         o_band_in   = p_band_ff;
         o_value_in  = p_ram_ff ? rd_data : '0;
         o_last_in   = p_last_ff;
      end
   end

   assign rsp_valid  = o_valid_ff;
   assign rsp_status = o_status_ff;
   assign rsp_kind   = o_kind_ff;
   assign rsp_band   = o_band_ff;
   assign rsp_value  = o_value_ff;
   assign rsp_last   = o_last_ff;

   a_end_when_idle: assert property (@(posedge clock) disable iff (reset)
      pkt_end.fire |-> !busy)
      else $error("packet end while results still draining");

   a_issue_fills_stage: assert property (@(posedge clock) disable iff (reset)
      issue |=> p_valid_ff && p_ram_ff)
      else $error("ram read issued but read stage not loaded");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff && !o_free |=> p_valid_ff && $stable(p_kind_ff) && $stable(p_band_ff))
      else $error("read stage lost while output stalled");

   a_last_ends_drain: assert property (@(posedge clock) disable iff (reset)
      issue && p_last_in |=> drain_ff == '0)
      else $error("last result issued with entries still pending");

endmodule

// ----- design/eeg_headset_packet_parser.sv -----
// ----------------------------------------------------------------------------
// eeg_headset_packet_parser
// serial packet parser for an eeg headset byte stream
// ----------------------------------------------------------------------------
// the request channel takes one received byte per cycle while req_stall is
// low (req_valid, req_stall, req_in_byte). the parser hunts two sync bytes,
// takes the length byte and parses the payload rows, writing each completed
// value into a twelve entry staging ram and marking it updated.
// on the checksum byte the updated entries are read back one per cycle while
// rsp_stall is low, lowest entry first, and sent on the result channel
// (rsp_valid, rsp_stall, rsp_status, rsp_kind, rsp_band, rsp_value, rsp_last).
// a checksum mismatch or a good packet with no known values gives a single
// status result. a status result passes the read stage and output register;
// value results are first set in the drain flags, then pass both.
// throughput: one byte per cycle while req_stall is low. while results drain,
// sync and length bytes of the next packet are still taken; its first payload
// byte is held off until the last result has left the read stage, as the
// drain shares the staging ram.
// a stalled result holds in the output register; one more waits in the read
// stage behind it. reset is synchronous, returns the parser to sync hunting
// and drops any pending results; the staging ram needs no clearing.
// ----------------------------------------------------------------------------
module eeg_headset_packet_parser
   import eeg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_kind,
   output logic [2:0]  rsp_band,
   output logic [23:0] rsp_value,
   output logic        rsp_last
);

   logic        req_accept;
   logic        need_ram;
   logic        busy;
   ram_wr_type  wr;
   pkt_end_type pkt_end;
   logic        rd_en;
   addr_type    rd_addr;
   value_type   rd_data;

   assign req_stall  = busy && need_ram;
   assign req_accept = req_valid && !req_stall;

   eeg_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_in_byte (req_in_byte),
      .need_ram    (need_ram),
      .wr          (wr),
      .pkt_end     (pkt_end)
   );

   eeg_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (ENTRY_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   eeg_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .pkt_end    (pkt_end),
      .busy       (busy),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_kind   (rsp_kind),
      .rsp_band   (rsp_band),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_last)
   );

   a_no_write_during_drain: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> !busy)
      else $error("staging write while results still draining");

endmodule
